// File: hw/rtl/bitmap_first_fit_allocator_macros.svh
// Assertion macros used by the allocator RTL (the request sequencer).
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bffa_pkg.sv
// Types and constants of the bitmap first-fit allocator.
package bffa_pkg;

  localparam int DWORD_COUNT     = 1024;
  localparam int RESERVED_DWORDS = 32;
  localparam int DWORD_BYTES     = 16;
  localparam int RESERVED_BYTES  = 256;

  localparam int IDX_W = $clog2(DWORD_COUNT);
  localparam int CNT_W = IDX_W + 1;

  // Largest request: segment bytes less the bitmap bytes and the reserved bytes.
  localparam int LIMIT_BYTES = DWORD_COUNT * DWORD_BYTES - DWORD_COUNT / 4 - RESERVED_BYTES;

  // Reserved head, clipped to the store.
  localparam int HEAD_DWORDS = (RESERVED_DWORDS > DWORD_COUNT) ? DWORD_COUNT : RESERVED_DWORDS;

  localparam int BYTES_W  = 16;
  localparam int FIDX_W   = 10;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 2;

  typedef enum logic [CODE_W-1:0] {
    CODE_FREE  = 2'd0,
    CODE_START = 2'd1,
    CODE_CONT  = 2'd2
  } bffa_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_SIZE  = 2'd2,
    ST_NOT_START = 2'd3
  } bffa_status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bffa_op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_MARK,
    S_FREE_SCAN,
    S_RESP
  } bffa_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   block_index;
  } bffa_rsp_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CODE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } bffa_mem_req_t;

endpackage

// File: hw/rtl/bffa_if.sv
// Request and result channel interfaces of the allocator.
interface bffa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] request_bytes;
  logic [9:0]  free_index;

  modport source (output valid, operation, request_bytes, free_index, input ready);
  modport sink (input valid, operation, request_bytes, free_index, output ready);
endinterface

interface bffa_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] block_index;

  modport source (output valid, status, block_index, input ready);
  modport sink (input valid, status, block_index, output ready);
endinterface

// File: hw/rtl/bffa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bffa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bffa_ctrl.sv
// Request sequencer: clearing pass, first-fit scan, block marking and block release.
`include "bitmap_first_fit_allocator_macros.svh"

module bffa_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  bffa_req_if.sink                          in_ch,
  output bffa_pkg::bffa_mem_req_t           mem_req,
  input  logic [bffa_pkg::CODE_W-1:0]       mem_rdata,
  output logic                              rsp_load,
  output bffa_pkg::bffa_rsp_t               rsp_data,
  input  logic                              slot_free
);
  import bffa_pkg::*;

  bffa_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic [IDX_W-1:0] chk_r, chk_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0] mark_r, mark_nxt;
  logic             first_r, first_nxt;
  bffa_rsp_t        rsp_r, rsp_nxt;

  logic             accept;
  logic             issue_live;
  logic [CNT_W-1:0] run_inc;
  logic [16:0]      bytes_round;
  logic [CNT_W-1:0] free_ext;

  assign accept      = in_ch.valid && in_ch.ready;
  assign issue_live  = (issue_r != CNT_W'(DWORD_COUNT));
  assign run_inc     = run_r + CNT_W'(1);
  assign bytes_round = {1'b0, in_ch.request_bytes} + 17'(DWORD_BYTES - 1);
  assign free_ext    = CNT_W'(in_ch.free_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mark_r  <= '0;
      chk_v_r <= 1'b0;
      issue_r <= '0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mark_r  <= mark_nxt;
      chk_v_r <= chk_v_nxt;
      issue_r <= issue_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    run_r   <= run_nxt;
    need_r  <= need_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    rsp_r   <= rsp_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    issue_nxt = issue_r;
    chk_nxt   = chk_r;
    chk_v_nxt = chk_v_r;
    run_nxt   = run_r;
    need_nxt  = need_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    mark_nxt  = mark_r;
    first_nxt = first_r;
    rsp_nxt   = rsp_r;

    in_ch.ready   = 1'b0;
    rsp_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = mark_r;
    mem_req.wdata = CODE_FREE;
    mem_req.re    = 1'b0;
    mem_req.raddr = issue_r[IDX_W-1:0];

    // Both scans stream one read a cycle; the data of the read issued last
    // cycle belongs to entry chk_r.
    if (state_r == S_ALLOC_SCAN || state_r == S_FREE_SCAN) begin
      mem_req.re = issue_live;
      chk_v_nxt  = issue_live;
      chk_nxt    = issue_r[IDX_W-1:0];
      if (issue_live) begin
        issue_nxt = issue_r + CNT_W'(1);
      end
    end

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = mark_r;
        if (mark_r == '0) begin
          mem_req.wdata = CODE_START;
        end else if ({1'b0, mark_r} < CNT_W'(HEAD_DWORDS)) begin
          mem_req.wdata = CODE_CONT;
        end else begin
          mem_req.wdata = CODE_FREE;
        end
        mark_nxt = mark_r + IDX_W'(1);
        if (mark_r == IDX_W'(DWORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          chk_v_nxt = 1'b0;
          rsp_nxt.block_index = '0;
          if (in_ch.operation == OP_FREE) begin
            if (free_ext >= CNT_W'(DWORD_COUNT)) begin
              rsp_nxt.status = ST_NOT_START;
              state_nxt      = S_RESP;
            end else begin
              issue_nxt = free_ext;
              first_nxt = 1'b1;
              state_nxt = S_FREE_SCAN;
            end
          end else begin
            if (in_ch.request_bytes == '0 ||
                {16'b0, in_ch.request_bytes} > 32'(LIMIT_BYTES)) begin
              rsp_nxt.status = ST_BAD_SIZE;
              state_nxt      = S_RESP;
            end else begin
              need_nxt  = CNT_W'(bytes_round >> 4);
              run_nxt   = '0;
              issue_nxt = '0;
              state_nxt = S_ALLOC_SCAN;
            end
          end
        end
      end

      S_ALLOC_SCAN: begin
        if (chk_v_r) begin
          if (mem_rdata == CODE_FREE) begin
            if (run_r == '0) begin
              start_nxt = chk_r;
            end
            run_nxt = run_inc;
            if (run_inc == need_r) begin
              end_nxt   = chk_r;
              mark_nxt  = (run_r == '0) ? chk_r : start_r;
              state_nxt = S_ALLOC_MARK;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!issue_live) begin
          rsp_nxt.status      = ST_NO_SPACE;
          rsp_nxt.block_index = '0;
          state_nxt           = S_RESP;
        end
      end

      S_ALLOC_MARK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = mark_r;
        mem_req.wdata = (mark_r == start_r) ? CODE_START : CODE_CONT;
        mark_nxt      = mark_r + IDX_W'(1);
        if (mark_r == end_r) begin
          rsp_nxt.status      = ST_OK;
          rsp_nxt.block_index = FIDX_W'(start_r);
          state_nxt           = S_RESP;
        end
      end

      S_FREE_SCAN: begin
        mem_req.waddr = chk_r;
        if (chk_v_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            if (mem_rdata != CODE_START) begin
              rsp_nxt.status = ST_NOT_START;
              state_nxt      = S_RESP;
            end else begin
              mem_req.we = 1'b1;
            end
          end else if (mem_rdata == CODE_CONT) begin
            mem_req.we = 1'b1;
          end else begin
            rsp_nxt.status = ST_OK;
            state_nxt      = S_RESP;
          end
        end else if (!issue_live) begin
          rsp_nxt.status = ST_OK;
          state_nxt      = S_RESP;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          rsp_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rsp_data = rsp_r;

  // A read and a write in the same cycle must never touch the same entry.
  `BFFA_ASSERT_NOW(a_no_rw_collision, mem_req.we && mem_req.re,
                   mem_req.waddr != mem_req.raddr, "read and write collide on one entry")
  // Marking never runs past the end of the run that was found.
  `BFFA_ASSERT_NOW(a_mark_in_run, state_r == S_ALLOC_MARK,
                   mark_r <= end_r && mark_r >= start_r, "mark write outside the found run")
  // A result is only handed over when the output slot can take it.
  `BFFA_ASSERT_NOW(a_load_into_free_slot, rsp_load, slot_free,
                   "result loaded into an occupied slot")
  // Each accepted request leaves the idle state in the next cycle.
  `BFFA_ASSERT_NEXT(a_busy_after_accept, accept, state_r != S_IDLE,
                    "request accepted but sequencer idle")

endmodule

// File: hw/rtl/bffa_out_reg.sv
// Result output register: holds one result until the sink takes it.
module bffa_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bffa_pkg::bffa_rsp_t data,
  output logic                slot_free,
  bffa_rsp_if.source          out_ch
);
  import bffa_pkg::*;

  logic      valid_r;
  bffa_rsp_t data_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.status      = data_r.status;
  assign out_ch.block_index = data_r.block_index;

endmodule

// File: hw/rtl/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator over a segment of 16-byte double words. One 2-bit code per
// double word (free, block start, continuation) lives in a 1024-entry RAM with a single read
// port and a single write port, and every request that gets past its size check walks that
// RAM one entry per cycle. After reset a clearing pass over all 1024 entries writes the
// reserved head and frees the rest; no request is taken during it. An allocate that is
// rejected on size is answered without a scan; otherwise it scans from entry 0 until a
// fitting run is found or the RAM ends, then marks the block one double word at a time and
// hands the result over. A free checks that the named entry is a block start, then releases
// it and its continuations. One request is in flight at a time; a result waits in an output
// register, so the next request can start while the previous result is not yet taken.
module bitmap_first_fit_allocator (
  input  logic       clk,
  input  logic       rst_n,
  bffa_req_if.sink   in_ch,
  bffa_rsp_if.source out_ch
);
  import bffa_pkg::*;

  bffa_mem_req_t     mem_req;
  logic [CODE_W-1:0] mem_rdata;
  logic              rsp_load;
  bffa_rsp_t         rsp_data;
  logic              slot_free;

  bffa_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DWORD_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .rsp_load  (rsp_load),
    .rsp_data  (rsp_data),
    .slot_free (slot_free)
  );

  bffa_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (rsp_load),
    .data      (rsp_data),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

// File: sim/tb_bitmap_first_fit_allocator.sv
// Self-checking testbench for the bitmap first-fit allocator, with its own allocation predictor.
module tb_bitmap_first_fit_allocator;
  import bffa_pkg::*;

  typedef struct {
    bffa_op_t    operation;
    logic [15:0] request_bytes;
    logic [9:0]  free_index;
  } alloc_req_t;

  logic clk;
  logic rst_n;

  bffa_req_if req_ch ();
  bffa_rsp_if rsp_ch ();

  bitmap_first_fit_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // Predicted code of every double word, updated as each request is transferred.
  bffa_code_t dword_codes [DWORD_COUNT];

  alloc_req_t pending_reqs [$];
  bffa_rsp_t  expected_rsps [$];
  alloc_req_t in_flight;
  bffa_rsp_t  oldest_rsp;

  int  n_queued;
  int  n_accepted;
  int  n_errors;
  int  send_gap;
  int  stall_left;
  bit  calm;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 11);
  endfunction

  // First fit over the predicted codes; a free clears the start and its continuations.
  function automatic bffa_rsp_t predict_request(alloc_req_t r);
    bffa_rsp_t rsp;
    int need;
    int run;
    int first;
    bit found;
    rsp.status      = ST_OK;
    rsp.block_index = '0;
    if (r.operation == OP_FREE) begin
      if (dword_codes[r.free_index] != CODE_START) begin
        rsp.status = ST_NOT_START;
      end else begin
        dword_codes[r.free_index] = CODE_FREE;
        for (int k = int'(r.free_index) + 1; k < DWORD_COUNT; k++) begin
          if (dword_codes[k] != CODE_CONT) break;
          dword_codes[k] = CODE_FREE;
        end
      end
    end else if (r.request_bytes == 0 || int'(r.request_bytes) > LIMIT_BYTES) begin
      rsp.status = ST_BAD_SIZE;
    end else begin
      need  = (int'(r.request_bytes) + DWORD_BYTES - 1) / DWORD_BYTES;
      run   = 0;
      first = 0;
      found = 1'b0;
      for (int k = 0; k < DWORD_COUNT && !found; k++) begin
        if (dword_codes[k] == CODE_FREE) begin
          if (run == 0) first = k;
          run++;
          if (run == need) begin
            found = 1'b1;
            dword_codes[first] = CODE_START;
            for (int m = first + 1; m <= k; m++) dword_codes[m] = CODE_CONT;
          end
        end else begin
          run = 0;
        end
      end
      if (found) begin
        rsp.block_index = first[9:0];
      end else begin
        rsp.status = ST_NO_SPACE;
      end
    end
    return rsp;
  endfunction

  // Picks a random live block start from the predicted codes, or -1 when there is none.
  function automatic int pick_live_start();
    int starts [$];
    for (int k = 0; k < DWORD_COUNT; k++) begin
      if (dword_codes[k] == CODE_START) starts.push_back(k);
    end
    if (starts.size() == 0) return -1;
    return starts[$urandom_range(0, starts.size() - 1)];
  endfunction

  task automatic queue_req(input bffa_op_t op, input int nbytes, input int idx);
    alloc_req_t r;
    while (pending_reqs.size() >= 2) @(negedge clk);
    r.operation     = op;
    r.request_bytes = nbytes[15:0];
    r.free_index    = idx[9:0];
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic wait_drained(input bit want_results);
    while (n_accepted != n_queued || (want_results && expected_rsps.size() != 0))
      @(negedge clk);
  endtask

  // Sender: holds each item until it is transferred, then waits its drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(predict_request(in_flight));
        n_accepted++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Item still offered; keep it steady.
      end else if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_flight = pending_reqs.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= in_flight.operation;
        req_ch.request_bytes <= in_flight.request_bytes;
        req_ch.free_index    <= in_flight.free_index;
        send_gap = draw_wait();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d index %0d",
                                    rsp_ch.status, rsp_ch.block_index));
        end else begin
          oldest_rsp = expected_rsps.pop_front();
          if (rsp_ch.status !== oldest_rsp.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp_ch.status, oldest_rsp.status));
          if (rsp_ch.block_index !== oldest_rsp.block_index)
            report_mismatch($sformatf("block index %0d, predicted %0d",
                                      rsp_ch.block_index, oldest_rsp.block_index));
        end
        stall_left = draw_wait();
      end
      // The stall only counts down while a result is actually on offer.
      if (stall_left > 0 && rsp_ch.valid) stall_left--;
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int pick;
    int live;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.free_index    = '0;
    rsp_ch.ready         = 1'b0;
    n_queued   = 0;
    n_accepted = 0;
    n_errors   = 0;
    calm       = 1'b0;
    for (int k = 0; k < DWORD_COUNT; k++) begin
      if (k == 0) dword_codes[k] = CODE_START;
      else if (k < HEAD_DWORDS) dword_codes[k] = CODE_CONT;
      else dword_codes[k] = CODE_FREE;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: size limits, a completely full store, holes and the reserved head.
    queue_req(OP_ALLOC, 0, 1023);
    queue_req(OP_ALLOC, 65535, 0);
    queue_req(OP_ALLOC, LIMIT_BYTES + 1, 0);
    queue_req(OP_ALLOC, LIMIT_BYTES, 0);
    queue_req(OP_ALLOC, 1, 0);
    queue_req(OP_FREE, 65535, HEAD_DWORDS);
    queue_req(OP_ALLOC, 1, 0);
    queue_req(OP_ALLOC, 16, 0);
    queue_req(OP_ALLOC, 17, 0);
    queue_req(OP_FREE, 0, HEAD_DWORDS + 1);
    queue_req(OP_ALLOC, 15, 0);
    queue_req(OP_FREE, 0, HEAD_DWORDS + 3);
    queue_req(OP_FREE, 0, 1023);
    queue_req(OP_FREE, 0, 500);
    queue_req(OP_FREE, 0, 0);
    queue_req(OP_ALLOC, 512, 0);
    queue_req(OP_FREE, 0, 0);
    queue_req(OP_FREE, 0, 0);
    queue_req(OP_ALLOC, 16, 0);
    queue_req(OP_ALLOC, 16 * (DWORD_COUNT - HEAD_DWORDS), 0);
    queue_req(OP_FREE, 0, 1);

    // Random part: mostly allocations and frees of live blocks, with some noise.
    for (int n = 0; n < 580; n++) begin
      if (n % 100 == 0) begin
        // Let the block drain completely now and then, and change the idling mood.
        wait_drained(1'b1);
        calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_req(OP_ALLOC, $urandom_range(1, 256), $urandom_range(0, 1023));
      end else if (pick < 60) begin
        queue_req(OP_ALLOC, $urandom_range(257, LIMIT_BYTES), $urandom_range(0, 1023));
      end else if (pick < 63) begin
        if ($urandom_range(0, 1) == 0) queue_req(OP_ALLOC, 0, $urandom_range(0, 1023));
        else queue_req(OP_ALLOC, $urandom_range(LIMIT_BYTES + 1, 65535), 0);
      end else if (pick < 93) begin
        // A free of a live block must see every earlier request already predicted.
        wait_drained(1'b0);
        live = pick_live_start();
        if (live < 0) live = $urandom_range(0, 1023);
        queue_req(OP_FREE, $urandom_range(0, 65535), live);
      end else begin
        queue_req(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 1023));
      end
    end

    wait_drained(1'b1);
    repeat (2100) @(posedge clk);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
